FILE: sv/bed_pkg.sv
// Shared types and constants for the button event detector.
package bed_pkg;

    localparam int BUTTON_W          = 3;
    localparam int STAMP_W           = 32;
    localparam int HOLD_W            = 32;
    localparam int ENTRY_W           = 6;
    localparam int SUB_MAX           = 8;
    localparam int TABLE_W           = ENTRY_W * SUB_MAX;
    localparam int BTN_SEL_W         = 2;
    localparam int BTN_SEL_N         = 1 << BTN_SEL_W;
    localparam int FIRE_W            = SUB_MAX;
    localparam int IN_TDATA_W        = 40;
    localparam int OUT_TDATA_W       = 16;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = TABLE_W;
    localparam int NUM_BUTTONS_DEF   = 3;
    localparam int NUM_SUBS_DEF      = 8;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd500000;

    typedef enum logic [2:0] {
        COND_DOWN     = 3'd0,
        COND_UP       = 3'd1,
        COND_PRESSED  = 3'd2,
        COND_RELEASED = 3'd3,
        COND_HOLD     = 3'd4
    } cond_t;

    typedef struct packed {
        cond_t                cond;
        logic [BTN_SEL_W-1:0] button;
        logic                 enable;
    } sub_entry_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TABLE = 1'b0,
        CFG_HOLD  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [FIRE_W-1:0]   fire_mask;
        logic [BUTTON_W-1:0] pressed_now;
    } eval_result_t;

endpackage

FILE: sv/bed_eval.sv
// Combinational evaluation of one poll against the subscription table.
module bed_eval #(
    parameter int NUM_BUTTONS       = bed_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_SUBSCRIPTIONS = bed_pkg::NUM_SUBS_DEF
) (
    input  logic [bed_pkg::BUTTON_W-1:0] buttons_raw,
    input  logic [bed_pkg::STAMP_W-1:0]  now_us,
    input  logic [bed_pkg::TABLE_W-1:0]  sub_table,
    input  logic [bed_pkg::HOLD_W-1:0]   hold_time,
    input  logic [NUM_BUTTONS-1:0]       prev_flags,
    input  logic [bed_pkg::STAMP_W-1:0]  stamp_cur [NUM_BUTTONS],
    output logic [NUM_BUTTONS-1:0]       pressed,
    output logic [bed_pkg::STAMP_W-1:0]  stamp_next [NUM_BUTTONS],
    output bed_pkg::eval_result_t        result
);
    import bed_pkg::*;

    logic [NUM_BUTTONS-1:0] changed;
    logic [NUM_BUTTONS-1:0] hold_ok;
    logic [STAMP_W-1:0]     stamp_eff [NUM_BUTTONS];
    logic [BTN_SEL_N-1:0]   cur4;
    logic [BTN_SEL_N-1:0]   prev4;
    logic [BTN_SEL_N-1:0]   hold_ok4;
    logic [BTN_SEL_N-1:0]   hold_seen;
    logic [BTN_SEL_N-1:0]   hold_fired;
    logic [FIRE_W-1:0]      fire;
    logic                   hold_zero;
    logic                   hit;
    logic                   entry_ok;
    sub_entry_t             entry;

    assign hold_zero = (hold_time == '0);

    // Pins beyond the port width read as released level inverted, i.e. pressed.
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        if (b < BUTTON_W) begin : g_pin
            assign pressed[b] = ~buttons_raw[b];
        end else begin : g_nopin
            assign pressed[b] = 1'b1;
        end
        assign changed[b]   = pressed[b] ^ prev_flags[b];
        assign stamp_eff[b] = changed[b] ? now_us : stamp_cur[b];
        assign hold_ok[b]   = pressed[b] && ((now_us - stamp_eff[b]) >= hold_time);
        if (b < BTN_SEL_N) begin : g_sel
            assign stamp_next[b] = hold_fired[b] ? now_us : stamp_eff[b];
        end else begin : g_nosel
            assign stamp_next[b] = stamp_eff[b];
        end
    end

    for (genvar s = 0; s < BTN_SEL_N; s++) begin : g_pad
        if (s < NUM_BUTTONS) begin : g_used
            assign cur4[s]     = pressed[s];
            assign prev4[s]    = prev_flags[s];
            assign hold_ok4[s] = hold_ok[s];
        end else begin : g_unused
            assign cur4[s]     = 1'b0;
            assign prev4[s]    = 1'b0;
            assign hold_ok4[s] = 1'b0;
        end
    end

    // A restart by the first firing hold entry leaves zero elapsed time, so later
    // hold entries of the same button fire only when the threshold is zero.
    always_comb
    begin
        fire       = '0;
        hold_seen  = '0;
        hold_fired = '0;
        entry      = '0;
        hit        = 1'b0;
        entry_ok   = 1'b0;
        for (int k = 0; k < SUB_MAX; k++) begin
            entry    = sub_entry_t'(sub_table[k*ENTRY_W +: ENTRY_W]);
            entry_ok = (k < NUM_SUBSCRIPTIONS) && entry.enable
                       && (int'(entry.button) < NUM_BUTTONS);
            hit      = 1'b0;
            if (entry_ok) begin
                unique case (entry.cond)
                    COND_DOWN:     hit = cur4[entry.button];
                    COND_UP:       hit = !cur4[entry.button];
                    COND_PRESSED:  hit = cur4[entry.button] && !prev4[entry.button];
                    COND_RELEASED: hit = !cur4[entry.button] && prev4[entry.button];
                    COND_HOLD:
                    begin
                        hit = hold_ok4[entry.button]
                              && (!hold_seen[entry.button] || hold_zero);
                        hold_seen[entry.button]  = 1'b1;
                        hold_fired[entry.button] = hold_fired[entry.button] | hit;
                    end
                    default:       hit = 1'b0;
                endcase
            end
            fire[k] = hit;
        end
    end

    always_comb
    begin
        result.fire_mask   = fire;
        result.pressed_now = '0;
        for (int b = 0; b < BUTTON_W; b++) begin
            if (b < NUM_BUTTONS) begin
                result.pressed_now[b] = cur4[b];
            end
        end
    end

endmodule

FILE: sv/button_event_detector.sv
// Top level of the button event detector: input stage, state and result register.
//
//  Channel   Direction  Transaction content
//  s_axis    in         one poll: buttons_raw, now_us
//  m_axis    out        one result per poll: fire_mask, pressed_now
//  cfg       in         register write: 0 subscription table, 1 hold time
//
// One poll per cycle sustained while m_axis_tready holds; an accepted poll's result
// reaches m_axis via the input register, then evaluation into the result register.
// Reset clears the button state, the stamps, the table and loads the default
// hold time of 500000 microseconds.
// A stalled result holds in the result register while one more poll waits in
// the input register; s_axis_tready drops only when both are full and blocked.
module button_event_detector #(
    parameter int NUM_BUTTONS       = bed_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_SUBSCRIPTIONS = bed_pkg::NUM_SUBS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Bits from the lowest: buttons_raw[2:0], now_us[34:3], zero padding.
    input  logic [bed_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Bits from the lowest: fire_mask[7:0], pressed_now[10:8], zero padding.
    output logic [bed_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [bed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bed_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [BUTTON_W-1:0]    in_raw_reg;
    logic [STAMP_W-1:0]     in_now_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    eval_result_t           out_result_reg;
    logic [NUM_BUTTONS-1:0] prev_flags_reg;
    logic [NUM_BUTTONS-1:0] prev_flags_next;
    logic [STAMP_W-1:0]     stamp_reg [NUM_BUTTONS];
    logic [STAMP_W-1:0]     stamp_next [NUM_BUTTONS];
    logic [TABLE_W-1:0]     table_reg;
    logic [HOLD_W-1:0]      hold_reg;
    logic                   advance;
    logic                   in_take;
    eval_result_t           eval_result;
    logic [BUTTON_W-1:0]    prev_view;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - FIRE_W - BUTTON_W){1'b0}},
                            out_result_reg.pressed_now, out_result_reg.fire_mask};

    bed_eval #(
        .NUM_BUTTONS       (NUM_BUTTONS),
        .NUM_SUBSCRIPTIONS (NUM_SUBSCRIPTIONS)
    ) u_eval (
        .buttons_raw (in_raw_reg),
        .now_us      (in_now_reg),
        .sub_table   (table_reg),
        .hold_time   (hold_reg),
        .prev_flags  (prev_flags_reg),
        .stamp_cur   (stamp_reg),
        .pressed     (prev_flags_next),
        .stamp_next  (stamp_next),
        .result      (eval_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_raw_reg <= s_axis_tdata[BUTTON_W-1:0];
            in_now_reg <= s_axis_tdata[BUTTON_W +: STAMP_W];
        end
        if (advance) begin
            out_result_reg <= eval_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_flags_reg <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                stamp_reg[b] <= '0;
            end
        end else if (advance) begin
            prev_flags_reg <= prev_flags_next;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                stamp_reg[b] <= stamp_next[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            table_reg <= '0;
            hold_reg  <= HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TABLE: table_reg <= cfg_wdata[TABLE_W-1:0];
                CFG_HOLD:  hold_reg  <= cfg_wdata[HOLD_W-1:0];
                default:   table_reg <= table_reg;
            endcase
        end
    end

    for (genvar b = 0; b < BUTTON_W; b++) begin : g_prev_view
        if (b < NUM_BUTTONS) begin : g_used
            assign prev_view[b] = prev_flags_reg[b];
        end else begin : g_unused
            assign prev_view[b] = 1'b0;
        end
    end

    // The held result always matches the button state it left behind.
    a_pressed_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_result_reg.pressed_now == prev_view))
        else $error("pressed_now differs from stored button state");

    a_advance_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("evaluated poll did not reach the result register");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(prev_flags_reg))
        else $error("button state changed without a transaction");

    a_unused_fire_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_result_reg.fire_mask >> NUM_SUBSCRIPTIONS) == '0))
        else $error("fire bit set for an entry beyond the table size");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are blocked");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the button event detector: directed and random polls.
module tb;
    import bed_pkg::*;

    localparam int          NUM_BTN       = NUM_BUTTONS_DEF;
    localparam int          BLOCKS        = 12;
    localparam int          BLOCK_POLLS   = 142;
    localparam int          HOLD_OFF      = 60;
    localparam logic [2:0]  COND_RESERVED = 3'd5;

    typedef struct packed {
        logic                is_cfg;
        cfg_reg_t            reg_sel;
        logic [TABLE_W-1:0]  value;
        logic [BUTTON_W-1:0] raw;
        logic [STAMP_W-1:0]  now;
        logic                pinned;
        logic [FIRE_W-1:0]   fire;
        logic [BUTTON_W-1:0] pressed;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    cfg_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    logic [BUTTON_W-1:0] model_pressed;
    logic [BUTTON_W-1:0] btn_prev;
    logic [STAMP_W-1:0]  btn_stamp [NUM_BTN];
    logic [TABLE_W-1:0]  sub_table;
    logic [HOLD_W-1:0]   hold_us;

    eval_result_t pending_results [$];
    plan_row_t    plan [$];
    logic         pin_valid;
    eval_result_t pin_result;
    int           mismatches;
    int           src_idle;
    int           dst_idle;
    logic         hold_req;

    button_event_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic add_row(input plan_row_t r);
        plan = {plan, r};
    endtask

    function automatic sub_entry_t make_entry(input logic en, input logic [1:0] btn,
                                              input logic [2:0] cond);
        sub_entry_t e;
        e.enable = en;
        e.button = btn;
        e.cond   = cond_t'(cond);
        return e;
    endfunction

    function automatic eval_result_t eval_poll(input logic [BUTTON_W-1:0] raw,
                                               input logic [STAMP_W-1:0] now);
        eval_result_t       r;
        logic [BUTTON_W-1:0] changed;
        sub_entry_t         e;
        logic [STAMP_W-1:0] elapsed;
        logic               cur;
        logic               was;
        logic               hit;
        r = '0;
        model_pressed = ~raw;
        changed = model_pressed ^ btn_prev;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            if (changed[b])
                btn_stamp[b] = now;
        end
        for (int k = 0; k < SUB_MAX; k++)
        begin
            e = sub_table[ENTRY_W*k +: ENTRY_W];
            if (!e.enable || int'(e.button) >= NUM_BTN)
                continue;
            cur = model_pressed[e.button];
            was = btn_prev[e.button];
            hit = 1'b0;
            case (e.cond)
                COND_DOWN:     hit = cur;
                COND_UP:       hit = !cur;
                COND_PRESSED:  hit = cur && !was;
                COND_RELEASED: hit = !cur && was;
                COND_HOLD:
                begin
                    elapsed = now - btn_stamp[e.button];
                    if (cur && elapsed >= hold_us)
                    begin
                        hit = 1'b1;
                        btn_stamp[e.button] = now;
                    end
                end
                default:       hit = 1'b0;
            endcase
            r.fire_mask[k] = hit;
        end
        btn_prev = model_pressed;
        r.pressed_now = model_pressed;
        return r;
    endfunction

    function automatic logic [TABLE_W-1:0] random_table();
        logic [TABLE_W-1:0] t;
        logic [2:0]         cond;
        for (int k = 0; k < SUB_MAX; k++)
        begin
            cond = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
            t[ENTRY_W*k +: ENTRY_W] = make_entry($urandom_range(99) < 85,
                                                 2'($urandom_range(3)), cond);
        end
        return t;
    endfunction

    function automatic plan_row_t poll_row(input logic [2:0] raw, input logic [31:0] now);
        plan_row_t r;
        r = '0;
        r.raw = raw;
        r.now = now;
        return r;
    endfunction

    function automatic plan_row_t pin_row(input logic [2:0] raw, input logic [31:0] now,
                                          input logic [7:0] fire, input logic [2:0] pressed);
        plan_row_t r;
        r = poll_row(raw, now);
        r.pinned  = 1'b1;
        r.fire    = fire;
        r.pressed = pressed;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_reg_t sel, input logic [47:0] value);
        plan_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.value   = value;
        return r;
    endfunction

    task automatic send_poll(input logic [2:0] raw, input logic [31:0] now, input logic pinned,
                             input logic [7:0] fire, input logic [2:0] pressed);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - BUTTON_W - STAMP_W){1'b0}}, now, raw};
        pin_valid = pinned;
        pin_result.fire_mask   = fire;
        pin_result.pressed_now = pressed;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [TABLE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_TABLE)
            sub_table = value;
        else
            hold_us = value[HOLD_W-1:0];
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : scoreboard
        eval_result_t predicted;
        eval_result_t oldest;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = eval_poll(s_axis_tdata[BUTTON_W-1:0],
                                      s_axis_tdata[BUTTON_W +: STAMP_W]);
                if (pin_valid)
                    predicted = pin_result;
                pending_results = {pending_results, predicted};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result transaction", 32'(m_axis_tdata), 0);
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_axis_tdata[FIRE_W-1:0] !== oldest.fire_mask)
                        report_mismatch("fire_mask", 32'(m_axis_tdata[FIRE_W-1:0]),
                                        32'(oldest.fire_mask));
                    if (m_axis_tdata[FIRE_W +: BUTTON_W] !== oldest.pressed_now)
                        report_mismatch("pressed_now", 32'(m_axis_tdata[FIRE_W +: BUTTON_W]),
                                        32'(oldest.pressed_now));
                    if (m_axis_tdata[OUT_TDATA_W-1:FIRE_W+BUTTON_W] !== '0)
                        report_mismatch("tdata padding",
                                        32'(m_axis_tdata[OUT_TDATA_W-1:FIRE_W+BUTTON_W]), 0);
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= dst_idle);
        end
    end

    initial
    begin
        logic [2:0]         raw;
        logic [2:0]         pin_level;
        logic [31:0]        clock_us;
        logic [31:0]        step_max;
        logic [31:0]        hold_pick;
        logic [TABLE_W-1:0] dir_table;
        plan_row_t          row;
        int                 idx;
        int                 guard;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TABLE;
        cfg_wdata     = '0;
        pin_valid     = 1'b0;
        pin_result    = '0;
        hold_req      = 1'b0;
        mismatches    = 0;
        src_idle      = 28;
        dst_idle      = 52;
        model_pressed = '0;
        btn_prev      = '0;
        for (int b = 0; b < NUM_BTN; b++)
            btn_stamp[b] = '0;
        sub_table = '0;
        hold_us   = HOLD_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        dir_table = {make_entry(1'b1, 2'd0, COND_RESERVED),
                     make_entry(1'b1, 2'd3, COND_DOWN),
                     make_entry(1'b1, 2'd1, COND_HOLD),
                     make_entry(1'b1, 2'd1, COND_HOLD),
                     make_entry(1'b1, 2'd0, COND_RELEASED),
                     make_entry(1'b1, 2'd2, COND_PRESSED),
                     make_entry(1'b1, 2'd1, COND_UP),
                     make_entry(1'b1, 2'd0, COND_DOWN)};

        add_row(pin_row(3'b111, 32'd0, 8'h00, 3'b000));
        add_row(pin_row(3'b000, 32'hFFFF_FFFF, 8'h00, 3'b111));
        add_row(cfg_row(CFG_TABLE, {TABLE_W{1'b1}}));
        add_row(pin_row(3'b010, 32'd5, 8'h00, 3'b101));
        add_row(pin_row(3'b101, 32'h8000_0000, 8'h00, 3'b010));
        add_row(cfg_row(CFG_TABLE, dir_table));
        add_row(cfg_row(CFG_HOLD, 48'd100));
        add_row(poll_row(3'b111, 32'd1000));
        add_row(poll_row(3'b110, 32'd1010));
        add_row(poll_row(3'b100, 32'd1020));
        add_row(poll_row(3'b100, 32'd1100));
        add_row(poll_row(3'b100, 32'd1120));
        add_row(poll_row(3'b100, 32'd1220));
        add_row(poll_row(3'b000, 32'd1230));
        add_row(poll_row(3'b111, 32'd1240));
        add_row(poll_row(3'b101, 32'hFFFF_FFC0));
        add_row(poll_row(3'b101, 32'h0000_0030));
        add_row(cfg_row(CFG_HOLD, 48'd0));
        add_row(poll_row(3'b101, 32'd40));
        add_row(poll_row(3'b101, 32'd40));
        add_row(poll_row(3'b111, 32'd41));
        add_row(cfg_row(CFG_HOLD, 48'hFFFF_FFFF));
        add_row(poll_row(3'b101, 32'd50));
        add_row(poll_row(3'b101, 32'd49));

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                wait_drained();
                write_reg(row.reg_sel, row.value);
            end
            else
                send_poll(row.raw, row.now, row.pinned, row.fire, row.pressed);
        end

        pin_level = 3'b111;
        clock_us  = $urandom();
        for (int b = 0; b < BLOCKS; b++)
        begin
            wait_drained();
            src_idle = (b < 4) ? 28 : (b < 8) ? 52 : 0;
            dst_idle = (b < 4) ? 52 : (b < 8) ? 28 : 0;
            case (b % 4)
                0:       hold_pick = $urandom_range(1, 60);
                1:       hold_pick = 32'd0;
                2:       hold_pick = $urandom_range(50, 1000);
                default: hold_pick = (b == 3) ? 32'hFFFF_FFFF : $urandom();
            endcase
            step_max = (hold_pick == 0) ? 32'd20 :
                       (hold_pick == 32'hFFFF_FFFF) ? 32'h4000_0000 : hold_pick / 3 + 2;
            write_reg(CFG_TABLE, random_table());
            write_reg(CFG_HOLD, {{(TABLE_W-HOLD_W){1'b0}}, hold_pick});
            if (b == 1 || b == 5)
                hold_req = 1'b1;
            for (int n = 0; n < BLOCK_POLLS; n++)
            begin
                idx = $urandom_range(99);
                if (idx < 8)
                    raw = 3'($urandom_range(7));
                else if (idx < 30)
                begin
                    raw = pin_level;
                    idx = $urandom_range(NUM_BTN - 1);
                    raw[idx] = ~raw[idx];
                end
                else
                    raw = pin_level;
                pin_level = raw;
                idx = $urandom_range(99);
                if (idx < 3)
                    clock_us = $urandom();
                else if (idx < 5)
                    clock_us = 32'hFFFF_FFFF - $urandom_range(300);
                else
                    clock_us = clock_us + $urandom_range(0, step_max);
                send_poll(raw, clock_us, 1'b0, 8'h00, 3'b000);
            end
        end

        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 5000 && pending_results.size() != 0; guard++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: filelist.f
sv/bed_pkg.sv
sv/bed_eval.sv
sv/button_event_detector.sv
tb/tb.sv
